// ===== hw/rtl/esa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_pkg: shared types and codes for the event slot allocator
// Slot, tag and count widths, request and status codes, sequencer states
// and the control structs passed to the free queue.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int TAG_W     = 31;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  localparam req_t REQ_ALLOC  = 2'd0;
  localparam req_t REQ_FREE   = 2'd1;
  localparam req_t REQ_LOOKUP = 2'd2;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_NONE = 2'd1;
  localparam status_t STAT_ERR  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_RESULT
  } state_t;

  // free queue pop and push request
  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
  } q_op_t;

  // free queue refill request
  typedef struct packed {
    logic   refill;
    count_t n;
  } q_cfg_t;

endpackage : esa_pkg
`default_nettype wire

// ===== hw/rtl/esa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : esa_ram
`default_nettype wire

// ===== hw/rtl/esa_free_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_free_queue: circular FIFO of free slot numbers
// Pop from head, push at tail, refill with 0..n-1 on a slot count write.
// ----------------------------------------------------------------------------
module esa_free_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire esa_pkg::q_cfg_t cfg,
  input  wire esa_pkg::q_op_t  op,
  output esa_pkg::slot_t       head_slot,
  output esa_pkg::count_t      count
);
  import esa_pkg::*;

  slot_t  q_r [MAX_SLOTS];
  slot_t  q_nxt [MAX_SLOTS];
  slot_t  head_r, head_nxt;
  count_t count_r, count_nxt;
  slot_t  tail;

  assign head_slot = q_r[head_r];
  assign count     = count_r;
  assign tail      = head_r + count_r[SLOT_W-1:0];

  always_comb begin
    q_nxt     = q_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cfg.refill) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        q_nxt[i] = (i < int'(cfg.n)) ? SLOT_W'(i) : '0;
      end
      head_nxt  = '0;
      count_nxt = cfg.n;
    end else if (op.pop) begin
      head_nxt  = head_r + SLOT_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end else if (op.push) begin
      q_nxt[tail] = op.push_slot;
      count_nxt   = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset holds a one-slot list: slot 0 only
      for (int i = 0; i < MAX_SLOTS; i++) begin
        q_r[i] <= '0;
      end
      head_r  <= '0;
      count_r <= CNT_W'(1);
    end else begin
      q_r     <= q_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule : esa_free_queue
`default_nettype wire

// ===== hw/rtl/event_slot_allocator.sv =====
`default_nettype none
// Result path: an accepted word sets the result registers and enters S_RESULT;
//   the result moves to the output word once that is free. A lookup first scans
//   in S_LOOKUP, one slot a cycle through one tag comparator, to the first hit.
// Flow: one word at a time, taken the cycle after the last result is registered.
// Reset (rst_n, synchronous): slot count 1, free list holds slot 0, no busy
//   slots, no result pending. Tag RAM contents are not cleared.
// ----------------------------------------------------------------------------
// event_slot_allocator: free-list slot allocator with event tags
// Allocates slots from a FIFO free list, frees them back, and looks up the
// lowest busy slot holding a given event number by a sequential tag scan.
// ----------------------------------------------------------------------------
module event_slot_allocator (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration: slot count
  input  wire logic             cfg_wr_en,
  input  wire esa_pkg::cfg_t    cfg_wr_data,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire esa_pkg::req_t    in_req_type,
  input  wire esa_pkg::tag_t    in_event_number,
  input  wire esa_pkg::slot_t   in_slot_index,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output esa_pkg::slot_t        out_slot_result,
  output esa_pkg::status_t      out_status,
  output esa_pkg::count_t       out_free_count
);
  import esa_pkg::*;

  // sequencer and request registers
  state_t  state_r, state_nxt;
  tag_t    evt_r, evt_nxt;
  count_t  scan_ptr_r, scan_ptr_nxt;   // next slot to read from the tag RAM
  logic    cmp_vld_r, cmp_vld_nxt;     // tag RAM data valid for compare
  slot_t   cmp_idx_r, cmp_idx_nxt;     // slot whose tag is on rd_data
  slot_t   res_slot_r, res_slot_nxt;
  status_t res_status_r, res_status_nxt;

  // slot state
  logic [MAX_SLOTS-1:0] busy_r, busy_nxt;
  count_t               siu_r, siu_nxt;  // managed slot count

  // output word register
  logic    out_valid_r, out_valid_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  status_t out_status_r, out_status_nxt;
  count_t  out_count_r, out_count_nxt;

  // free queue and tag RAM hookup
  q_cfg_t q_cfg;
  q_op_t  q_op;
  slot_t  q_head_slot;
  count_t q_count;

  logic   tag_wr_en;
  logic   tag_rd_en;
  tag_t   tag_rd_data;
  logic   accept;
  count_t cfg_n;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign tag_rd_en = (state_r == S_LOOKUP) && (scan_ptr_r < CNT_W'(MAX_SLOTS));

  // slot count write: zero reads as one, oversize clamps to the maximum
  always_comb begin
    cfg_n = CNT_W'(cfg_wr_data);
    if (cfg_wr_data == '0) begin
      cfg_n = CNT_W'(1);
    end else if (cfg_wr_data > CFG_W'(MAX_SLOTS)) begin
      cfg_n = CNT_W'(MAX_SLOTS);
    end
  end

  assign q_cfg.refill = cfg_wr_en;
  assign q_cfg.n      = cfg_n;

  esa_free_queue u_free_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (q_cfg),
    .op        (q_op),
    .head_slot (q_head_slot),
    .count     (q_count)
  );

  // allocate writes the tag at the popped slot; lookup reads one slot a cycle
  esa_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (q_head_slot),
    .wr_data (in_event_number),
    .rd_en   (tag_rd_en),
    .rd_addr (scan_ptr_r[SLOT_W-1:0]),
    .rd_data (tag_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    evt_nxt        = evt_r;
    scan_ptr_nxt   = scan_ptr_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    busy_nxt       = busy_r;
    siu_nxt        = siu_r;
    q_op           = '0;
    tag_wr_en      = 1'b0;

    // output register drains when the far side takes the word
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_slot_nxt   = '0;
          res_status_nxt = STAT_ERR;
          state_nxt      = S_RESULT;
          case (in_req_type)
            REQ_ALLOC: begin
              if (q_count == '0) begin
                res_status_nxt = STAT_NONE;
              end else begin
                q_op.pop                = 1'b1;
                tag_wr_en               = 1'b1;
                busy_nxt[q_head_slot]   = 1'b1;
                res_slot_nxt            = q_head_slot;
                res_status_nxt          = STAT_OK;
              end
            end
            REQ_FREE: begin
              // out-of-range and double frees are rejected, nothing changes
              if ((CNT_W'(in_slot_index) < siu_r) && busy_r[in_slot_index]) begin
                q_op.push               = 1'b1;
                q_op.push_slot          = in_slot_index;
                busy_nxt[in_slot_index] = 1'b0;
                res_status_nxt          = STAT_OK;
              end
            end
            REQ_LOOKUP: begin
              evt_nxt      = in_event_number;
              scan_ptr_nxt = '0;
              state_nxt    = S_LOOKUP;
            end
            default: begin
              res_status_nxt = STAT_ERR;
            end
          endcase
        end
      end

      S_LOOKUP: begin
        if (tag_rd_en) begin
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_ptr_r[SLOT_W-1:0];
        end
        // lowest slot wins: first hit in scan order stops the search
        if (cmp_vld_r && busy_r[cmp_idx_r] && (tag_rd_data == evt_r)) begin
          res_slot_nxt   = cmp_idx_r;
          res_status_nxt = STAT_OK;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_RESULT;
        end else if (cmp_vld_r && (cmp_idx_r == SLOT_W'(MAX_SLOTS - 1))) begin
          res_slot_nxt   = '0;
          res_status_nxt = STAT_NONE;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_RESULT;
        end
      end

      S_RESULT: begin
        // free count is read after the queue update has landed
        if (!out_valid_nxt) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = q_count;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // slot count write only while idle (user's rule, unchecked): frees everything
    if (cfg_wr_en) begin
      siu_nxt  = cfg_n;
      busy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      busy_r      <= '0;
      siu_r       <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      busy_r      <= busy_nxt;
      siu_r       <= siu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    evt_r        <= evt_nxt;
    scan_ptr_r   <= scan_ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_slot_result = out_slot_r;
  assign out_status      = out_status_r;
  assign out_free_count  = out_count_r;

  // every managed slot is either busy or on the free list
  a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(busy_r) + int'(q_count)) == int'(siu_r))
    else $error("busy plus free slots differs from slot count");

  // free list never holds more than the managed slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= siu_r)
    else $error("free count above slot count");

  // no slot at or beyond the slot count is ever busy
  a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r >> siu_r) == '0)
    else $error("busy slot outside the managed range");

  // a failed request always reports slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_slot_r == '0))
    else $error("non-zero slot on failed request");

endmodule : event_slot_allocator
`default_nettype wire

// ===== test/event_slot_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_slot_allocator_test: self-checking bench for the slot allocator
// Drives allocate, free, lookup and bad request words under random gaps and
// back-pressure, predicts every result word from its own copy of the free
// list and tags, and compares each result field by field.
// ----------------------------------------------------------------------------
module event_slot_allocator_test;
  import esa_pkg::*;

  localparam req_t REQ_BAD     = 2'd3;  // undefined request code
  localparam tag_t TAG_TOP     = '1;
  localparam int   IDLE_LIMIT  = 3000;  // cycles with no word moving on either side
  localparam int   PHASE_WORDS = 105;

  // one expected result word
  typedef struct packed {
    slot_t   slot;
    status_t status;
    count_t  spare;
  } answer_t;

  // Mirror of the allocator: free ring, busy flags and tags, plus the queue
  // of result words still owed by the block.
  class slot_board;
    int unsigned slot_count;
    slot_t       free_ring[MAX_SLOTS];
    slot_t       ring_head;
    count_t      ring_fill;
    bit          held[MAX_SLOTS];
    tag_t        owner[MAX_SLOTS];
    answer_t     pending[$];
    int          errors;
    int          results;

    function new();
      slot_count = 1;
      errors     = 0;
      results    = 0;
      foreach (owner[i]) owner[i] = '0;
      refill();
    endfunction

    function void refill();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        free_ring[i] = (i < slot_count) ? slot_t'(i) : '0;
        held[i]      = 1'b0;
      end
      ring_head = '0;
      ring_fill = count_t'(slot_count);
    endfunction

    // zero reads as one, anything past the array saturates
    function void set_count(cfg_t v);
      if (v == 0)
        slot_count = 1;
      else if (v > MAX_SLOTS)
        slot_count = MAX_SLOTS;
      else
        slot_count = v;
      refill();
    endfunction

    // random busy slot, or -1 when none is busy
    function int busy_slot();
      int list[$];
      for (int i = 0; i < MAX_SLOTS; i++)
        if (held[i]) list.push_back(i);
      if (list.size() == 0) return -1;
      return list[$urandom_range(0, list.size() - 1)];
    endfunction

    // one accepted request word: update the mirror, queue the answer
    function void note_word(req_t r, tag_t e, slot_t s);
      answer_t a;
      slot_t   popped;
      a = '{slot: '0, status: STAT_ERR, spare: '0};
      case (r)
        REQ_ALLOC: begin
          if (ring_fill == 0) begin
            a.status = STAT_NONE;
          end else begin
            popped         = free_ring[ring_head];
            ring_head      = ring_head + 1'b1;
            ring_fill      = ring_fill - 1'b1;
            held[popped]   = 1'b1;
            owner[popped]  = e;
            a.slot         = popped;
            a.status       = STAT_OK;
          end
        end
        REQ_FREE: begin
          // out of range and double free both leave everything alone
          if (s < slot_count && held[s]) begin
            free_ring[slot_t'(ring_head + ring_fill)] = s;
            held[s]   = 1'b0;
            ring_fill = ring_fill + 1'b1;
            a.status  = STAT_OK;
          end
        end
        REQ_LOOKUP: begin
          // scan downwards so the lowest matching slot wins
          a.status = STAT_NONE;
          for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (held[i] && owner[i] == e) begin
              a.slot   = slot_t'(i);
              a.status = STAT_OK;
            end
          end
        end
        default: ;
      endcase
      a.spare = ring_fill;
      pending.push_back(a);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check(slot_t sl, status_t st, count_t fc);
      answer_t a;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result word with none expected (slot %0d status %0d free %0d)",
                         sl, st, fc));
        return;
      end
      a = pending.pop_front();
      if (sl !== a.slot)
        report($sformatf("slot_result %0d, expected %0d", sl, a.slot));
      if (st !== a.status)
        report($sformatf("status %0d, expected %0d", st, a.status));
      if (fc !== a.spare)
        report($sformatf("free_count %0d, expected %0d", fc, a.spare));
    endtask
  endclass

  logic    clk             = 1'b0;
  logic    rst_n           = 1'b0;
  logic    cfg_wr_en       = 1'b0;
  cfg_t    cfg_wr_data     = '0;
  logic    in_valid        = 1'b0;
  logic    in_stall;
  req_t    in_req_type     = REQ_ALLOC;
  tag_t    in_event_number = '0;
  slot_t   in_slot_index   = '0;
  logic    out_valid;
  logic    out_stall       = 1'b0;
  slot_t   out_slot_result;
  status_t out_status;
  count_t  out_free_count;

  slot_board board;
  bit        calm = 1'b0;   // set for the stretch with no idling on either side
  int        words_sent = 0;
  int        settings   = 0;
  int        idle_cycles = 0;

  event_slot_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_event_number (in_event_number),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_result (out_slot_result),
    .out_status      (out_status),
    .out_free_count  (out_free_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each word taken, then choose next cycle's stall.
  // Everything read here is the value from before this edge.
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      board.check(out_slot_result, out_status, out_free_count);
    if (!rst_n || calm)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < 33);
  end

  // Watchdog: a run that stops moving words is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present one request word and hold it until taken. A random gap may come
  // first; valid is only lowered at steps where it is not raised again.
  task automatic send_word(req_t r, tag_t e, slot_t s);
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_req_type     <= r;
    in_event_number <= e;
    in_slot_index   <= s;
    do @(posedge clk); while (in_stall);
    board.note_word(r, e, s);
    words_sent++;
  endtask

  // Stop sending and wait for every owed result; every word gives one, so
  // once the last one is taken the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Slot count write, only ever from idle.
  task automatic set_slot_count(cfg_t v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_count(v);
    settings++;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: frees aim at busy slots, lookups at live
  // tags, and half the tags come from two small pools so that slots can share one.
  task automatic random_word();
    int    roll;
    int    busy;
    req_t  r;
    tag_t  e;
    slot_t s;
    roll = $urandom_range(0, 99);
    s    = slot_t'($urandom_range(0, MAX_SLOTS - 1));
    case ($urandom_range(0, 3))
      0:       e = tag_t'($urandom_range(0, 7));
      1:       e = TAG_TOP - tag_t'($urandom_range(0, 7));
      default: e = tag_t'($urandom());
    endcase
    busy = board.busy_slot();
    if (roll < 40) begin
      r = REQ_ALLOC;
    end else if (roll < 75) begin
      r = REQ_FREE;
      if (busy >= 0 && $urandom_range(0, 3) != 0) s = slot_t'(busy);
    end else if (roll < 97) begin
      r = REQ_LOOKUP;
      if (busy >= 0 && $urandom_range(0, 4) < 3) e = board.owner[busy];
    end else begin
      r = REQ_BAD;
    end
    send_word(r, e, s);
  endtask

  initial begin
    cfg_t plan[6];
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed, single slot out of reset --
    send_word(REQ_LOOKUP, '0, '0);        // lookup with nothing busy
    send_word(REQ_ALLOC, TAG_TOP, '0);    // takes slot 0, top tag
    send_word(REQ_ALLOC, '0, '0);         // queue empty
    send_word(REQ_LOOKUP, TAG_TOP, '0);   // hit
    send_word(REQ_LOOKUP, '0, '0);        // miss with a slot busy
    send_word(REQ_FREE, '0, slot_t'(MAX_SLOTS - 1));  // beyond slot count
    send_word(REQ_FREE, '0, '0);          // good free
    send_word(REQ_FREE, '0, '0);          // double free
    send_word(REQ_BAD, TAG_TOP, '1);      // undefined request

    // -- directed, all ones written: saturates to the full array --
    set_slot_count('1);
    send_word(REQ_ALLOC, tag_t'(42), '0);
    send_word(REQ_ALLOC, tag_t'(42), '0);
    send_word(REQ_LOOKUP, tag_t'(42), '0);  // two holders, lowest wins
    send_word(REQ_FREE, '0, '0);
    send_word(REQ_LOOKUP, tag_t'(42), '0);  // now the other holder
    send_word(REQ_ALLOC, tag_t'(85), '0);   // oldest free slot, not slot 0
    send_word(REQ_FREE, '0, slot_t'(MAX_SLOTS - 1));  // in range, not busy
    send_word(REQ_LOOKUP, TAG_TOP, '0);

    // -- random phases across slot counts; zero reads as one, 17 saturates --
    plan = '{cfg_t'(0), cfg_t'(16), cfg_t'(3), cfg_t'(17),
             cfg_t'($urandom_range(0, 31)), cfg_t'($urandom_range(1, 16))};
    foreach (plan[p]) begin
      set_slot_count(plan[p]);
      calm = (p == 2);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 3 && k == PHASE_WORDS / 2)
          settle();   // sender holds off until the block has drained
        random_word();
      end
    end
    calm = 1'b0;

    settle();
    repeat (25) @(posedge clk);

    $display("covered %0d request words and %0d result words over %0d slot count writes",
             words_sent, board.results, settings);
    $display("allocate, free, lookup and bad requests under random gaps and stalls");
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
